// File: hdl/lla_pkg.sv
`default_nettype none
package lla_pkg;
  localparam int MaxWidth  = 64;
  localparam int MaxHeight = 64;
  localparam int XW = $clog2(MaxWidth);
  localparam int YW = $clog2(MaxHeight);
  localparam int AW = XW + YW;
  localparam int Cells = MaxWidth * MaxHeight;

  localparam logic [2:0] CmdSet   = 3'd0;
  localparam logic [2:0] CmdRead  = 3'd1;
  localparam logic [2:0] CmdClear = 3'd2;
  localparam logic [2:0] CmdFill  = 3'd3;
  localparam logic [2:0] CmdStep  = 3'd4;

  localparam logic [2:0] RegWidth   = 3'd0;
  localparam logic [2:0] RegHeight  = 3'd1;
  localparam logic [2:0] RegBirth   = 3'd2;
  localparam logic [2:0] RegSurvive = 3'd3;
  localparam logic [2:0] RegNbEn    = 3'd4;
  localparam logic [2:0] RegEdge    = 3'd5;

  localparam logic [1:0] EdgeDead  = 2'd0;
  localparam logic [1:0] EdgeWrap  = 2'd1;
  localparam logic [1:0] EdgeAlive = 2'd2;

  // classified command handed from front to back
  typedef struct packed {
    logic [2:0]    cmd;
    logic          on_grid;
    logic          outv;
    logic [AW-1:0] addr;
    logic          val;
  } job_t;
endpackage
`default_nettype wire

// File: hdl/life_like_automaton_step_unit.sv
`default_nettype none
// Life-like automaton on a 64x64 cell plane. Commands go in on start/busy;
// every command gives one result pulse on out_valid which the receiver must
// take in that cycle, it cannot stall the block. After reset the engine clears
// plane zero; commands sent meanwhile wait in the queue. Clear and fill go
// one cell a cycle through the plane memory port; a generation step does
// nine reads through the single read port plus a write for each cell inside
// the grid and copies each cell outside it. A two-entry queue sits between
// the command front and the plane engine, so busy rises only once two
// commands wait behind the one being executed.
module life_like_automaton_step_unit (
  input  wire  logic       clk,
  input  wire  logic       rst_n,
  input  wire  logic       start,
  output logic             busy,
  input  wire  logic [2:0] in_cmd,
  input  wire  logic [5:0] in_x_coord,
  input  wire  logic [5:0] in_y_coord,
  input  wire  logic       in_cell_value,
  output logic             out_valid,
  output logic             out_read_value,
  output logic [2:0]       out_done_cmd,
  input  wire  logic       cfg_valid,
  output logic             cfg_ready,
  input  wire  logic [2:0] cfg_index,
  input  wire  logic [8:0] cfg_data
);
  logic [6:0] w_r, h_r;
  logic [8:0] birth_r, survive_r;
  logic [7:0] nben_r;
  logic [1:0] edge_r;
  logic [6:0] w_used, h_used;
  logic       q_full, q_valid, q_pop;
  lla_pkg::job_t q_job;

  assign cfg_ready = 1'b1;
  assign busy = q_full;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r <= 7'd64; h_r <= 7'd64; birth_r <= 9'd8; survive_r <= 9'd12;
      nben_r <= 8'hff; edge_r <= 2'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        lla_pkg::RegWidth:   w_r <= cfg_data[6:0];
        lla_pkg::RegHeight:  h_r <= cfg_data[6:0];
        lla_pkg::RegBirth:   birth_r <= cfg_data;
        lla_pkg::RegSurvive: survive_r <= cfg_data;
        lla_pkg::RegNbEn:    nben_r <= cfg_data[7:0];
        lla_pkg::RegEdge:    edge_r <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // clamp grid size
  assign w_used = (w_r == 7'd0) ? 7'd1 : (w_r > 7'(lla_pkg::MaxWidth)) ?
                  7'(lla_pkg::MaxWidth) : w_r;
  assign h_used = (h_r == 7'd0) ? 7'd1 : (h_r > 7'(lla_pkg::MaxHeight)) ?
                  7'(lla_pkg::MaxHeight) : h_r;

  lla_front u_front (
    .clk, .rst_n, .in_valid(start && !busy), .cmd(in_cmd), .x_coord(in_x_coord),
    .y_coord(in_y_coord), .cell_value(in_cell_value), .w_used, .h_used,
    .edge_mode(edge_r), .q_full, .q_valid, .q_job, .q_pop
  );

  lla_back u_back (
    .clk, .rst_n, .q_valid, .q_job, .q_pop, .w_used, .h_used,
    .birth_mask(birth_r), .survive_mask(survive_r), .neighbour_enable(nben_r),
    .edge_mode(edge_r), .out_valid, .read_value(out_read_value),
    .done_cmd(out_done_cmd)
  );
endmodule
`default_nettype wire

// File: hdl/lla_front.sv
`default_nettype none
// accepts commands, resolves coordinates and queues them for the engine
module lla_front (
  input  wire  logic                   clk,
  input  wire  logic                   rst_n,
  input  wire  logic                   in_valid,
  input  wire  logic [2:0]             cmd,
  input  wire  logic [5:0]             x_coord,
  input  wire  logic [5:0]             y_coord,
  input  wire  logic                   cell_value,
  input  wire  logic [6:0]             w_used,
  input  wire  logic [6:0]             h_used,
  input  wire  logic [1:0]             edge_mode,
  output logic                         q_full,
  output logic                         q_valid,
  output lla_pkg::job_t                q_job,
  input  wire  logic                   q_pop
);
  logic [12:0] xr, yr;
  logic        on_grid;
  lla_pkg::job_t job_in;
  lla_pkg::job_t slot_r [2];
  logic          wp_r, rp_r;
  logic [1:0]    cnt_r;

  // wrap coordinates by restoring subtraction of the shifted grid size
  // (quotient bits five down to zero, wide enough for the shifted size)
  always_comb begin
    xr = {7'd0, x_coord};
    yr = {7'd0, y_coord};
    for (int i = 0; i < 6; i++) begin
      if (xr >= ({6'd0, w_used} << (5 - i))) xr = xr - ({6'd0, w_used} << (5 - i));
      if (yr >= ({6'd0, h_used} << (5 - i))) yr = yr - ({6'd0, h_used} << (5 - i));
    end
    on_grid = ({1'b0, x_coord} < w_used) && ({1'b0, y_coord} < h_used);
    job_in.cmd  = cmd;
    job_in.val  = cell_value;
    job_in.outv = (edge_mode == lla_pkg::EdgeAlive);
    if (edge_mode == lla_pkg::EdgeWrap) begin
      job_in.on_grid = 1'b1;
      job_in.addr    = {yr[lla_pkg::YW-1:0], xr[lla_pkg::XW-1:0]};
    end else begin
      job_in.on_grid = on_grid;
      job_in.addr    = {y_coord, x_coord};
    end
  end

  // two-entry queue
  always_ff @(posedge clk) begin
    if (in_valid) slot_r[wp_r] <= job_in;
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (in_valid) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(in_valid) - 2'(q_pop);
    end
  end

  assign q_full  = (cnt_r == 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign q_job   = slot_r[rp_r];

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_valid && q_full)) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid) else $error("queue underflow");
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("queue count bad");
`endif
endmodule
`default_nettype wire

// File: hdl/lla_back.sv
`default_nettype none
// executes commands on the two cell planes, one cell at a time for a step
module lla_back (
  input  wire  logic          clk,
  input  wire  logic          rst_n,
  input  wire  logic          q_valid,
  input  wire  lla_pkg::job_t q_job,
  output logic                q_pop,
  input  wire  logic [6:0]    w_used,
  input  wire  logic [6:0]    h_used,
  input  wire  logic [8:0]    birth_mask,
  input  wire  logic [8:0]    survive_mask,
  input  wire  logic [7:0]    neighbour_enable,
  input  wire  logic [1:0]    edge_mode,
  output logic                out_valid,
  output logic                read_value,
  output logic [2:0]          done_cmd
);
  localparam int AW = lla_pkg::AW;
  localparam int XW = lla_pkg::XW;
  localparam int YW = lla_pkg::YW;
  localparam logic signed [XW+1:0] XOne = 1;
  localparam logic signed [YW+1:0] YOne = 1;

  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SRead  = 3'd1;
  localparam logic [2:0] SSweep = 3'd2;
  localparam logic [2:0] SCell  = 3'd3;
  localparam logic [2:0] SFetch = 3'd4;
  localparam logic [2:0] SWrite = 3'd5;
  localparam logic [2:0] SInit  = 3'd6;

  logic mem0 [lla_pkg::Cells];
  logic mem1 [lla_pkg::Cells];

  logic [2:0]    st_r;
  logic          front_r;
  lla_pkg::job_t job_r;
  logic [AW:0]   sweep_r;
  logic [3:0]    nb_r;
  logic [3:0]    cnt_r;
  logic          self_r;
  logic          rd0_r, rd1_r;
  logic          nb_skip_r, nb_const_r;

  logic [XW-1:0] cx;
  logic [YW-1:0] cy;
  logic          in_grid;
  logic          rdbit;
  logic          gen_bit;
  logic [AW-1:0] raddr;
  logic          nb_skip, nb_const, nb_out;
  logic [XW:0]   nx;
  logic [YW:0]   ny;

  assign cx = sweep_r[XW-1:0];
  assign cy = sweep_r[AW-1:XW];
  assign in_grid = ({1'b0, cx} < w_used[XW:0]) && ({1'b0, cy} < h_used[YW:0]);
  assign rdbit = front_r ? rd1_r : rd0_r;
  // cells outside the grid are copied, the rest follow the rule masks
  assign gen_bit = !in_grid ? self_r : (self_r ? survive_mask[cnt_r] : birth_mask[cnt_r]);

  // neighbour coordinates with edge handling
  always_comb begin
    logic signed [XW+1:0] sx;
    logic signed [YW+1:0] sy;
    logic [2:0] k;
    k = nb_r[2:0];
    sx = $signed({2'b00, cx});
    sy = $signed({2'b00, cy});
    case (k)
      3'd0: begin sx = sx - XOne; sy = sy - YOne; end
      3'd1: sy = sy - YOne;
      3'd2: begin sx = sx + XOne; sy = sy - YOne; end
      3'd3: sx = sx - XOne;
      3'd4: sx = sx + XOne;
      3'd5: begin sx = sx - XOne; sy = sy + YOne; end
      3'd6: sy = sy + YOne;
      default: begin sx = sx + XOne; sy = sy + YOne; end
    endcase
    nb_out = (sx < 0) || (sy < 0) || (sx >= $signed({1'b0, w_used[XW:0]}))
             || (sy >= $signed({1'b0, h_used[YW:0]}));
    if (sx < 0) sx = sx + $signed({1'b0, w_used[XW:0]});
    else if (sx >= $signed({1'b0, w_used[XW:0]})) sx = sx - $signed({1'b0, w_used[XW:0]});
    if (sy < 0) sy = sy + $signed({1'b0, h_used[YW:0]});
    else if (sy >= $signed({1'b0, h_used[YW:0]})) sy = sy - $signed({1'b0, h_used[YW:0]});
    nx = sx[XW:0];
    ny = sy[YW:0];
    nb_skip  = !neighbour_enable[k] || (nb_out && edge_mode != lla_pkg::EdgeWrap);
    nb_const = neighbour_enable[k] && nb_out && edge_mode == lla_pkg::EdgeAlive;
    case (st_r)
      SIdle:   raddr = q_job.addr;
      SFetch:  raddr = {ny[YW-1:0], nx[XW-1:0]};
      default: raddr = sweep_r[AW-1:0];
    endcase
  end

  // plane memories, registered read
  always_ff @(posedge clk) begin
    rd0_r <= mem0[raddr];
    rd1_r <= mem1[raddr];
    if (st_r == SInit && !sweep_r[AW]) mem0[sweep_r[AW-1:0]] <= 1'b0;
    if (st_r == SSweep && !sweep_r[AW]) begin
      if (!front_r) mem0[sweep_r[AW-1:0]] <= (job_r.cmd == lla_pkg::CmdFill);
      else          mem1[sweep_r[AW-1:0]] <= (job_r.cmd == lla_pkg::CmdFill);
    end
    if (st_r == SIdle && q_valid && q_job.cmd == lla_pkg::CmdSet && q_job.on_grid) begin
      if (!front_r) mem0[q_job.addr] <= q_job.val;
      else          mem1[q_job.addr] <= q_job.val;
    end
    if (st_r == SWrite) begin
      if (front_r) mem0[sweep_r[AW-1:0]] <= gen_bit;
      else         mem1[sweep_r[AW-1:0]] <= gen_bit;
    end
  end

  assign q_pop = (st_r == SIdle) && q_valid;

  // command sequencer
  always_ff @(posedge clk) begin
    nb_skip_r  <= nb_skip;
    nb_const_r <= nb_const;
    if (!rst_n) begin
      st_r <= SInit; front_r <= 1'b0; out_valid <= 1'b0;
      read_value <= 1'b0; done_cmd <= 3'd0;
      sweep_r <= '0; nb_r <= '0; cnt_r <= '0; self_r <= 1'b0; job_r <= '0;
    end else begin
      out_valid <= 1'b0;
      case (st_r)
        // clearing pass over plane zero after reset, no result
        SInit: if (sweep_r[AW]) begin
          sweep_r <= '0;
          st_r <= SIdle;
        end else sweep_r <= sweep_r + 1'b1;
        SIdle: if (q_valid) begin
          job_r <= q_job;
          sweep_r <= '0;
          case (q_job.cmd)
            lla_pkg::CmdRead: st_r <= SRead;
            lla_pkg::CmdClear, lla_pkg::CmdFill: st_r <= SSweep;
            lla_pkg::CmdStep: st_r <= SCell;
            default: begin
              out_valid <= 1'b1; read_value <= 1'b0; done_cmd <= q_job.cmd;
            end
          endcase
        end
        SRead: begin
          out_valid <= 1'b1; done_cmd <= job_r.cmd;
          read_value <= job_r.on_grid ? rdbit : job_r.outv;
          st_r <= SIdle;
        end
        SSweep: if (sweep_r[AW]) begin
          out_valid <= 1'b1; read_value <= 1'b0; done_cmd <= job_r.cmd;
          st_r <= SIdle;
        end else sweep_r <= sweep_r + 1'b1;
        SCell: begin
          // own cell read issued here through the sweep address, seen in SFetch
          if (sweep_r[AW]) begin
            front_r <= ~front_r;
            out_valid <= 1'b1; read_value <= 1'b0; done_cmd <= job_r.cmd;
            st_r <= SIdle;
          end else begin
            nb_r <= 4'd0; cnt_r <= 4'd0; st_r <= SFetch;
          end
        end
        SFetch: begin
          if (!in_grid) begin
            self_r <= rdbit; cnt_r <= 4'd0; st_r <= SWrite;
          end else begin
            if (nb_r == 4'd0) self_r <= rdbit;
            else if (!nb_skip_r || nb_const_r)
              cnt_r <= cnt_r + 4'(nb_const_r ? 1'b1 : rdbit);
            if (nb_r == 4'd8) st_r <= SWrite;
            else nb_r <= nb_r + 1'b1;
          end
        end
        SWrite: begin
          sweep_r <= sweep_r + 1'b1;
          st_r <= SCell;
        end
        default: st_r <= SIdle;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid || $past(st_r) == SIdle) else $error("extra result");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> st_r != SIdle || out_valid) else $error("pop lost");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 4'd8) else $error("count over eight");
`endif
endmodule
`default_nettype wire
